FILE: design/assert_macros.svh
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is active
`define AST_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication, disabled while reset is active
`define AST_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

FILE: design/arp_pkg.sv
// ----------------------------------------------------------------------------
// arp_pkg
// Shared constants, result codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package arp_pkg;

	// default table depth
	localparam int ENTRIES_DEF = 8;

	// field widths
	localparam int IP_W   = 32;
	localparam int MAC_W  = 48;
	localparam int ACT_W  = 3;
	localparam int CIDX_W = 2;

	// result action codes
	localparam logic [ACT_W-1:0] ACT_DROP      = 3'd0;
	localparam logic [ACT_W-1:0] ACT_REPLY     = 3'd1;
	localparam logic [ACT_W-1:0] ACT_UPDATED   = 3'd2;
	localparam logic [ACT_W-1:0] ACT_HIT       = 3'd3;
	localparam logic [ACT_W-1:0] ACT_BROADCAST = 3'd4;
	localparam logic [ACT_W-1:0] ACT_MISS      = 3'd5;

	// configuration register indexes
	localparam logic [CIDX_W-1:0] REG_LOCAL   = 2'd0;
	localparam logic [CIDX_W-1:0] REG_MASK    = 2'd1;
	localparam logic [CIDX_W-1:0] REG_GATEWAY = 2'd2;

	// arp header values
	localparam logic [15:0] HW_TYPE_ETH    = 16'h0001;
	localparam logic [15:0] PROTO_IPV4     = 16'h0800;
	localparam logic [7:0]  HW_LEN_ETH     = 8'd6;
	localparam logic [7:0]  PROTO_LEN_IPV4 = 8'd4;
	localparam logic [15:0] OP_REQUEST     = 16'd1;
	localparam logic [15:0] OP_REPLY       = 16'd2;

	localparam logic [IP_W-1:0]  ALL_ONES_IP  = '1;
	localparam logic [MAC_W-1:0] ALL_ONES_MAC = '1;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic scan;
		logic write;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic need_scan;
		logic is_store;
		logic scan_done;
	} sts_t;

endpackage

FILE: design/arp_cache_next_hop_resolver_core.sv
// Sequence: a dropped packet, reply or broadcast passes the decide and out states before
// done strobes; a lookup adds the table scan, and a table store adds the scan and a write.
// Throughput: one item at a time; busy falls with the done strobe, so a new item
// can start in that cycle. For lookups and stores the serial table scan, one entry per cycle, sets it.
// Results are never held off: done is a one-cycle strobe and the receiver cannot stall.
// Reset: arst_n clears config registers and all valid bits at once; no sweep.
// ----------------------------------------------------------------------------
// arp_cache_next_hop_resolver_core
// ARP binding cache and next-hop resolver: controller plus datapath.
// ----------------------------------------------------------------------------
module arp_cache_next_hop_resolver_core #(
	parameter int ENTRIES = arp_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic                        cfg_we,
	input  logic [arp_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [arp_pkg::IP_W-1:0]    cfg_data,
	input  logic                        mode,
	input  logic                        short_frame,
	input  logic [15:0]                 hw_type,
	input  logic [15:0]                 proto_type,
	input  logic [7:0]                  hw_len,
	input  logic [7:0]                  proto_len,
	input  logic [15:0]                 opcode,
	input  logic [arp_pkg::MAC_W-1:0]   sender_mac,
	input  logic [arp_pkg::IP_W-1:0]    sender_ip,
	input  logic [arp_pkg::IP_W-1:0]    target_addr,
	input  logic [arp_pkg::IP_W-1:0]    dest_address,
	output logic                        done,
	output logic [arp_pkg::ACT_W-1:0]   action,
	output logic [arp_pkg::MAC_W-1:0]   peer_mac,
	output logic [arp_pkg::IP_W-1:0]    peer_ip
);
	import arp_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// sequencer
	arp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.cmd    (cmd),
		.sts    (sts)
	);

	// datapath and table
	arp_dpath #(
		.ENTRIES (ENTRIES)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mode         (mode),
		.short_frame  (short_frame),
		.hw_type      (hw_type),
		.proto_type   (proto_type),
		.hw_len       (hw_len),
		.proto_len    (proto_len),
		.opcode       (opcode),
		.sender_mac   (sender_mac),
		.sender_ip    (sender_ip),
		.target_addr  (target_addr),
		.dest_address (dest_address),
		.done         (done),
		.action       (action),
		.peer_mac     (peer_mac),
		.peer_ip      (peer_ip)
	);

endmodule

FILE: design/arp_ctrl.sv
// ----------------------------------------------------------------------------
// arp_ctrl
// Sequencer: decode, table scan, table write and result issue.
// ----------------------------------------------------------------------------
module arp_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	output arp_pkg::cmd_t cmd,
	input  arp_pkg::sts_t sts
);
	import arp_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SCAN,
		ST_WRITE,
		ST_OUT
	} state_t;

	state_t state_q;
	logic   busy_q;

	// state and busy flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			busy_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECIDE;
						busy_q  <= 1'b1;
					end
				end
				ST_DECIDE: begin
					state_q <= sts.need_scan ? ST_SCAN : ST_OUT;
				end
				ST_SCAN: begin
					if (sts.scan_done) begin
						state_q <= sts.is_store ? ST_WRITE : ST_OUT;
					end
				end
				ST_WRITE: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
				default: begin
					state_q <= ST_IDLE;
					busy_q  <= 1'b0;
				end
			endcase
		end
	end

	// commands decoded from state
	always_comb begin
		cmd       = '0;
		cmd.load  = (state_q == ST_IDLE) && start;
		cmd.scan  = (state_q == ST_SCAN);
		cmd.write = (state_q == ST_WRITE);
		cmd.emit  = (state_q == ST_OUT);
	end

	assign busy = busy_q;

endmodule

FILE: design/arp_dpath.sv
// ----------------------------------------------------------------------------
// arp_dpath
// Item decode, config registers, binding table with serial scan, result regs.
// ----------------------------------------------------------------------------
module arp_dpath #(
	parameter int ENTRIES = arp_pkg::ENTRIES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  arp_pkg::cmd_t               cmd,
	output arp_pkg::sts_t               sts,
	input  logic                        cfg_we,
	input  logic [arp_pkg::CIDX_W-1:0]  cfg_index,
	input  logic [arp_pkg::IP_W-1:0]    cfg_data,
	input  logic                        mode,
	input  logic                        short_frame,
	input  logic [15:0]                 hw_type,
	input  logic [15:0]                 proto_type,
	input  logic [7:0]                  hw_len,
	input  logic [7:0]                  proto_len,
	input  logic [15:0]                 opcode,
	input  logic [arp_pkg::MAC_W-1:0]   sender_mac,
	input  logic [arp_pkg::IP_W-1:0]    sender_ip,
	input  logic [arp_pkg::IP_W-1:0]    target_addr,
	input  logic [arp_pkg::IP_W-1:0]    dest_address,
	output logic                        done,
	output logic [arp_pkg::ACT_W-1:0]   action,
	output logic [arp_pkg::MAC_W-1:0]   peer_mac,
	output logic [arp_pkg::IP_W-1:0]    peer_ip
);
	import arp_pkg::*;

	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

	typedef enum logic [2:0] {
		K_DROP,
		K_REPLY,
		K_STORE,
		K_BCAST,
		K_LOOKUP
	} kind_t;

	// configuration
	logic [IP_W-1:0] local_q, mask_q, gw_q;

	// latched item
	kind_t            kind_q;
	logic [IP_W-1:0]  key_q;
	logic [MAC_W-1:0] mac_q;

	// table storage
	logic [IP_W-1:0]  entry_ip  [ENTRIES];
	logic [MAC_W-1:0] entry_mac [ENTRIES];
	logic [ENTRIES-1:0] valid_q;

	// scan state
	logic             issue_q;
	logic [IDX_W-1:0] rd_idx_q;
	logic             cmp_en_s1, cmp_last_s1, vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic [IP_W-1:0]  ip_rd_s1;
	logic [MAC_W-1:0] mac_rd_s1;
	logic             found_q, free_q;
	logic [IDX_W-1:0] hit_idx_q, free_idx_q;
	logic [MAC_W-1:0] hit_mac_q;

	// results
	logic             done_q;
	logic [ACT_W-1:0] action_q;
	logic [MAC_W-1:0] peer_mac_q;
	logic [IP_W-1:0]  peer_ip_q;

	// decode signals
	logic             fmt_ok, bcast, route_en, off_net;
	logic [IP_W-1:0]  hop;
	kind_t            kind_d;
	logic             hit;
	logic [IDX_W-1:0] slot;

	// classify the incoming item against the current config
	always_comb begin
		fmt_ok   = !short_frame && (hw_type == HW_TYPE_ETH) && (proto_type == PROTO_IPV4)
		           && (hw_len == HW_LEN_ETH) && (proto_len == PROTO_LEN_IPV4);
		bcast    = (dest_address == ALL_ONES_IP) || (local_q == '0);
		route_en = (mask_q != '0) && (gw_q != '0);
		off_net  = (local_q & mask_q) != (dest_address & mask_q);
		hop      = (route_en && off_net && !bcast) ? gw_q : dest_address;
		if (mode) begin
			kind_d = bcast ? K_BCAST : K_LOOKUP;
		end else if (!fmt_ok) begin
			kind_d = K_DROP;
		end else if (opcode == OP_REPLY) begin
			kind_d = K_STORE;
		end else if ((opcode == OP_REQUEST) && (local_q != '0) && (target_addr == local_q)) begin
			kind_d = K_REPLY;
		end else begin
			kind_d = K_DROP;
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_q <= '0;
			mask_q  <= '0;
			gw_q    <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LOCAL:   local_q <= cfg_data;
				REG_MASK:    mask_q  <= cfg_data;
				REG_GATEWAY: gw_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// item capture
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			kind_q <= K_DROP;
		end else if (cmd.load) begin
			kind_q <= kind_d;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			key_q <= mode ? hop : sender_ip;
			mac_q <= sender_mac;
		end
	end

	// table read port, one entry per cycle
	always_ff @(posedge clk) begin
		ip_rd_s1   <= entry_ip[rd_idx_q];
		mac_rd_s1  <= entry_mac[rd_idx_q];
		vld_s1     <= valid_q[rd_idx_q];
		cmp_idx_s1 <= rd_idx_q;
	end

	// scan address issue
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			issue_q     <= 1'b0;
			rd_idx_q    <= '0;
			cmp_en_s1   <= 1'b0;
			cmp_last_s1 <= 1'b0;
		end else if (cmd.load) begin
			issue_q     <= 1'b1;
			rd_idx_q    <= '0;
			cmp_en_s1   <= 1'b0;
			cmp_last_s1 <= 1'b0;
		end else begin
			cmp_en_s1   <= cmd.scan && issue_q;
			cmp_last_s1 <= (rd_idx_q == LAST_IDX);
			if (cmd.scan && issue_q) begin
				if (rd_idx_q == LAST_IDX) begin
					issue_q <= 1'b0;
				end else begin
					rd_idx_q <= rd_idx_q + 1'b1;
				end
			end
		end
	end

	// compare stage: first match and first free slot
	assign hit = cmp_en_s1 && vld_s1 && (ip_rd_s1 == key_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else if (cmd.load) begin
			found_q <= 1'b0;
			free_q  <= 1'b0;
		end else begin
			if (hit && !found_q) begin
				found_q <= 1'b1;
			end
			if (cmp_en_s1 && !vld_s1 && !free_q) begin
				free_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit && !found_q) begin
			hit_idx_q <= cmp_idx_s1;
			hit_mac_q <= mac_rd_s1;
		end
		if (cmp_en_s1 && !vld_s1 && !free_q) begin
			free_idx_q <= cmp_idx_s1;
		end
	end

	// slot for a store: matching entry, else first free, else slot zero
	always_comb begin
		priority if (found_q) begin
			slot = hit_idx_q;
		end else if (free_q) begin
			slot = free_idx_q;
		end else begin
			slot = '0;
		end
	end

	// table write port
	always_ff @(posedge clk) begin
		if (cmd.write) begin
			entry_ip[slot]  <= key_q;
			entry_mac[slot] <= mac_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (cmd.write) begin
			valid_q[slot] <= 1'b1;
		end
	end

	// result registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			unique case (kind_q)
				K_REPLY: begin
					action_q   <= ACT_REPLY;
					peer_mac_q <= mac_q;
					peer_ip_q  <= key_q;
				end
				K_STORE: begin
					action_q   <= ACT_UPDATED;
					peer_mac_q <= mac_q;
					peer_ip_q  <= key_q;
				end
				K_BCAST: begin
					action_q   <= ACT_BROADCAST;
					peer_mac_q <= ALL_ONES_MAC;
					peer_ip_q  <= key_q;
				end
				K_LOOKUP: begin
					action_q   <= found_q ? ACT_HIT : ACT_MISS;
					peer_mac_q <= found_q ? hit_mac_q : '0;
					peer_ip_q  <= key_q;
				end
				default: begin
					action_q   <= ACT_DROP;
					peer_mac_q <= '0;
					peer_ip_q  <= '0;
				end
			endcase
		end
	end

	// status to controller
	always_comb begin
		sts           = '0;
		sts.need_scan = (kind_q == K_STORE) || (kind_q == K_LOOKUP);
		sts.is_store  = (kind_q == K_STORE);
		sts.scan_done = cmp_en_s1 && cmp_last_s1;
	end

	assign done     = done_q;
	assign action   = action_q;
	assign peer_mac = peer_mac_q;
	assign peer_ip  = peer_ip_q;

endmodule

FILE: design/arp_checker.sv
// ----------------------------------------------------------------------------
// arp_checker
// Port-level checks on the resolver core, attached by bind.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module arp_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic                      done,
	input logic [arp_pkg::ACT_W-1:0] action,
	input logic [arp_pkg::MAC_W-1:0] peer_mac
);
	import arp_pkg::*;

	// an accepted item makes the block busy
	`AST_NXT(a_accept_busy, clk, arst_n, start && !busy, busy)
	// the result strobe ends the busy period
	`AST_IMP(a_done_idle, clk, arst_n, done, !busy)
	// one strobe per item, never two in a row
	`AST_NXT(a_done_pulse, clk, arst_n, done, !done)
	// a broadcast result carries the all-ones mac
	`AST_IMP(a_bcast_mac, clk, arst_n, done && (action == ACT_BROADCAST), peer_mac == ALL_ONES_MAC)
	// drops and misses carry a zero mac
	`AST_IMP(a_zero_mac, clk, arst_n, done && ((action == ACT_DROP) || (action == ACT_MISS)),
		peer_mac == '0)

endmodule

bind arp_cache_next_hop_resolver_core arp_checker u_arp_checker (.*);
